// ----- src/goa_pkg.sv -----
`timescale 1ns / 1ps
// goa_pkg: shared types and constants of the gradient optical flow average block
// no dependencies

package goa_pkg;

  // defaults for the top-level size parameters
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  // configuration reset values
  localparam logic [11:0] RST_FRAME_WIDTH  = 12'd1280;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd720;

  // |Ix*It|*256 always fits this many bits
  localparam int PIX_NUM_BITS = 24;
  // result bits of the flow magnitude root
  localparam int ROOT_STEPS   = 17;
  localparam int GRAY_SCALE   = 50;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_FDIV,
    ST_SQ,
    ST_SQ2,
    ST_ROOT,
    ST_PUT,
    ST_CNT,
    ST_SDIV,
    ST_SPUT
  } state_t;

endpackage

// ----- src/goa_div.sv -----
`timescale 1ns / 1ps
// goa_div: iterative unsigned restoring divider, one quotient bit per cycle
// standalone; numerator is left-aligned by the caller to the step count

module goa_div #(
  parameter int NW = 40,
  parameter int DW = 24,
  parameter int SW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] steps,
  output logic          done,
  output logic [NW-1:0] quo
);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] work_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, work_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = work_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == SW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      cnt_r  <= steps;
      rem_r  <= '0;
      work_r <= num;
      den_r  <= den;
    end else if (busy_r) begin
      rem_r  <= ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      work_r <= {work_r[NW-2:0], ge};
      cnt_r  <= cnt_r - SW'(1);
    end
  end

endmodule

// ----- src/gradient_optical_flow_average.sv -----
`timescale 1ns / 1ps
// gradient_optical_flow_average: normal flow from two grey frames with frame averages
// a border pixel is taken in without a result; an interior pixel passes through the 4 line-store reads,
// two 24-step divides in goa_div (both skipped with zero gradient) and the 17-step square root,
// and a stalled output holds it in ST_PUT
// frame end adds the three average divides and the summary result
// one pixel pair in flight at a time; reset clears control, sums and config, not line stores
// depends on goa_pkg and goa_div

module gradient_optical_flow_average
  import goa_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  // pixel pair input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_frame1_pixel,
  input  logic [7:0]         in_frame2_pixel,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_summary,
  output logic [10:0]        out_pixel_x,
  output logic [10:0]        out_pixel_y,
  output logic signed [16:0] out_flow_x,
  output logic signed [16:0] out_flow_y,
  output logic [15:0]        out_magnitude,
  output logic [7:0]         out_magnitude_gray,
  output logic [15:0]        out_max_magnitude,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  // column and row counter widths
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  // interior pixel count and frame sums
  localparam int CNTW = XW + YW;
  localparam int SUMW = CNTW + 18;
  // shared divider
  localparam int NW   = (SUMW > PIX_NUM_BITS) ? SUMW : PIX_NUM_BITS;
  localparam int DW   = (CNTW > 17) ? CNTW : 17;
  localparam int SW   = $clog2(NW + 1);
  // line stores: three frame-one rows, two frame-two rows
  localparam int F1D  = 3 * MAX_WIDTH;
  localparam int F2D  = 2 * MAX_WIDTH;
  localparam int F1AW = $clog2(F1D);
  localparam int F2AW = $clog2(F2D);

  state_t state_r, state_nxt;

  logic [11:0] fw_r, fh_r;
  logic [XW-1:0] w_last, col_r, c_cur, c_r;
  logic [YW-1:0] h_last, row_r, r_cur, r_r;
  logic row_end, frame_end, compute_cur, in_accept, out_free;

  // rotating bank numbers of the line stores
  logic [1:0] f1_now_r, f1_ctr_r, f1_abv_r, rd_ctr_r, rd_abv_r;
  logic       f2_now_r, f2_ctr_r, rd_f2_r;

  logic [7:0] f1_mem [0:F1D-1];
  logic [7:0] f2_mem [0:F2D-1];
  logic [7:0] f1_q_r, f2_q_r;
  logic [F1AW-1:0] f1_ra, f1_wa;
  logic [F2AW-1:0] f2_ra, f2_wa;
  logic [1:0]      rd_bank;
  logic [XW-1:0]   rd_col;

  logic [7:0] prev_r, pv_r, a0_r, a1_r, a2_r, ab_r, t2_r;
  logic [2:0] rd_cnt_r;
  logic       fe_r;

  // gradients and products
  logic signed [8:0]  ix, iy, it;
  logic signed [17:0] pxt, pyt, ixx, iyy;
  logic [15:0] nx_mag_r, ny_mag_r;
  logic        nx_neg_r, ny_neg_r;
  logic [16:0] d_r;

  // divider
  logic          div_run_r, div_start, div_done;
  logic [1:0]    div_idx_r;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;
  logic [SW-1:0] div_steps;
  logic [SUMW-1:0] abs_sx, abs_sy;

  // flow, root
  logic signed [16:0] fx_r, fy_r;
  logic [33:0] sq_r, v_r, root_r, bit_r, root_add;
  logic [4:0]  root_cnt_r;
  logic [15:0] mag;
  logic [21:0] gray_prod;
  logic [7:0]  gray;

  // frame sums
  logic signed [SUMW-1:0] sum_fx_r, sum_fy_r;
  logic [SUMW-1:0] sum_m_r;
  logic [15:0]     peak_r;
  logic [CNTW-1:0] cnt_r;
  logic signed [16:0] ax_r, ay_r;
  logic [15:0]     am_r;
  logic signed [16:0] avg_s;
  logic [15:0]     avg_m;
  logic            avg_neg;

  // output register
  logic               out_valid_r, out_sum_r;
  logic [10:0]        out_x_r, out_y_r;
  logic signed [16:0] out_fx_r, out_fy_r;
  logic [15:0]        out_mag_r, out_max_r;
  logic [7:0]         out_gray_r;

  goa_div #(.NW(NW), .DW(DW), .SW(SW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo)
  );

  // size clamped to the supported range, as last column / row index
  always_comb begin
    if (fw_r < 12'd3) begin
      w_last = XW'(2);
    end else if (int'(fw_r) > MAX_WIDTH) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(fw_r - 12'd1);
    end
    if (fh_r < 12'd3) begin
      h_last = YW'(2);
    end else if (int'(fh_r) > MAX_HEIGHT) begin
      h_last = YW'(MAX_HEIGHT - 1);
    end else begin
      h_last = YW'(fh_r - 12'd1);
    end
  end

  // a counter beyond a shrunk size is taken as the last column or row
  assign c_cur       = (col_r < w_last) ? col_r : w_last;
  assign r_cur       = (row_r < h_last) ? row_r : h_last;
  assign row_end     = (c_cur == w_last);
  assign frame_end   = row_end && (r_cur == h_last);
  assign compute_cur = (c_cur >= XW'(2)) && (r_cur >= YW'(2));

  // gradients around the center pixel (c-1, r-1)
  assign ix  = $signed({1'b0, a0_r}) - $signed({1'b0, a2_r});
  assign iy  = $signed({1'b0, pv_r}) - $signed({1'b0, ab_r});
  assign it  = $signed({1'b0, t2_r}) - $signed({1'b0, a1_r});
  assign pxt = ix * it;
  assign pyt = iy * it;
  assign ixx = ix * ix;
  assign iyy = iy * iy;

  assign root_add  = root_r + bit_r;
  assign mag       = root_r[15:0];
  assign gray_prod = 22'(mag) * 22'(GRAY_SCALE);
  assign gray      = (gray_prod[21:8] > 14'd255) ? 8'd255 : gray_prod[15:8];

  assign abs_sx = sum_fx_r[SUMW-1] ? SUMW'(-sum_fx_r) : SUMW'(sum_fx_r);
  assign abs_sy = sum_fy_r[SUMW-1] ? SUMW'(-sum_fy_r) : SUMW'(sum_fy_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept && compute_cur) state_nxt = ST_READ;
      ST_READ: if (rd_cnt_r == 3'd4) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_FDIV;
      ST_FDIV: begin
        if (d_r == 17'd0) begin
          state_nxt = ST_SQ;
        end else if (div_done && div_idx_r == 2'd1) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:   state_nxt = ST_SQ2;
      ST_SQ2:  state_nxt = ST_ROOT;
      ST_ROOT: if (root_cnt_r == 5'd0) state_nxt = ST_PUT;
      ST_PUT:  if (out_free) state_nxt = fe_r ? ST_CNT : ST_IDLE;
      ST_CNT:  state_nxt = ST_SDIV;
      ST_SDIV: if (div_done && div_idx_r == 2'd2) state_nxt = ST_SPUT;
      ST_SPUT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshakes, divider operands and line-store addresses
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_accept = in_valid && (state_r == ST_IDLE);
    cfg_ready = 1'b1;
    out_free  = !out_valid_r || !out_stall;

    div_start = !div_run_r &&
                ((state_r == ST_FDIV && d_r != 17'd0) || state_r == ST_SDIV);
    div_num   = '0;
    div_den   = DW'(cnt_r);
    div_steps = SW'(NW);
    if (state_r == ST_FDIV) begin
      div_num   = NW'(div_idx_r[0] ? {ny_mag_r, 8'd0} : {nx_mag_r, 8'd0}) << (NW - PIX_NUM_BITS);
      div_den   = DW'(d_r);
      div_steps = SW'(PIX_NUM_BITS);
    end else begin
      case (div_idx_r)
        2'd0:    div_num = NW'(abs_sx);
        2'd1:    div_num = NW'(abs_sy);
        default: div_num = NW'(sum_m_r);
      endcase
    end

    // reads: center[c], center[c-2], center[c-1], above[c-1]
    case (rd_cnt_r)
      3'd0:    begin rd_bank = rd_ctr_r; rd_col = c_r;            end
      3'd1:    begin rd_bank = rd_ctr_r; rd_col = c_r - XW'(2);   end
      3'd2:    begin rd_bank = rd_ctr_r; rd_col = c_r - XW'(1);   end
      3'd3:    begin rd_bank = rd_abv_r; rd_col = c_r - XW'(1);   end
      default: begin rd_bank = rd_ctr_r; rd_col = c_r;            end
    endcase
    f1_ra = F1AW'(rd_bank) * F1AW'(MAX_WIDTH) + F1AW'(rd_col);
    f2_ra = F2AW'(rd_f2_r) * F2AW'(MAX_WIDTH) + F2AW'(c_r - XW'(1));
    f1_wa = F1AW'(f1_now_r) * F1AW'(MAX_WIDTH) + F1AW'(c_cur);
    f2_wa = F2AW'(f2_now_r) * F2AW'(MAX_WIDTH) + F2AW'(c_cur);
  end

  // summary average: signed quotient saturated to the field range
  always_comb begin
    avg_neg = (div_idx_r == 2'd0) ? sum_fx_r[SUMW-1] : sum_fy_r[SUMW-1];
    if (avg_neg) begin
      avg_s = (div_quo > NW'(65536)) ? 17'h10000 : -(17'(div_quo));
    end else begin
      avg_s = (div_quo > NW'(65535)) ? 17'h0FFFF : 17'(div_quo);
    end
    avg_m = (div_quo > NW'(65535)) ? 16'hFFFF : 16'(div_quo);
  end

  // line stores: new row written at transfer, one read per cycle after
  always_ff @(posedge clk) begin
    if (in_accept) begin
      f1_mem[f1_wa] <= in_frame1_pixel;
      f2_mem[f2_wa] <= in_frame2_pixel;
    end
    f1_q_r <= f1_mem[f1_ra];
    f2_q_r <= f2_mem[f2_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fw_r        <= RST_FRAME_WIDTH;
      fh_r        <= RST_FRAME_HEIGHT;
      col_r       <= '0;
      row_r       <= '0;
      prev_r      <= '0;
      f1_now_r    <= 2'd0;
      f1_ctr_r    <= 2'd1;
      f1_abv_r    <= 2'd2;
      f2_now_r    <= 1'b0;
      f2_ctr_r    <= 1'b1;
      rd_cnt_r    <= '0;
      div_run_r   <= 1'b0;
      div_idx_r   <= '0;
      root_cnt_r  <= '0;
      sum_fx_r    <= '0;
      sum_fy_r    <= '0;
      sum_m_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  fw_r <= cfg_data;
          REG_FRAME_HEIGHT: fh_r <= cfg_data;
          default: ;
        endcase
      end

      // the put states load the output register themselves
      if (out_valid_r && !out_stall && state_r != ST_PUT && state_r != ST_SPUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            // capture what the neighborhood reads need, then advance position
            c_r      <= c_cur;
            r_r      <= r_cur;
            fe_r     <= frame_end;
            pv_r     <= prev_r;
            prev_r   <= in_frame1_pixel;
            rd_ctr_r <= f1_ctr_r;
            rd_abv_r <= f1_abv_r;
            rd_f2_r  <= f2_ctr_r;
            rd_cnt_r <= '0;
            if (row_end) begin
              f1_abv_r <= f1_ctr_r;
              f1_ctr_r <= f1_now_r;
              f1_now_r <= f1_abv_r;
              f2_ctr_r <= f2_now_r;
              f2_now_r <= f2_ctr_r;
              col_r    <= '0;
              row_r    <= frame_end ? '0 : r_cur + YW'(1);
            end else begin
              col_r    <= c_cur + XW'(1);
              row_r    <= r_cur;
            end
          end
        end

        ST_READ: begin
          // read data is registered and arrives in the cycle after its address
          rd_cnt_r <= rd_cnt_r + 3'd1;
          case (rd_cnt_r)
            3'd1: begin a0_r <= f1_q_r; t2_r <= f2_q_r; end
            3'd2: a2_r <= f1_q_r;
            3'd3: a1_r <= f1_q_r;
            3'd4: ab_r <= f1_q_r;
            default: ;
          endcase
        end

        ST_PREP: begin
          nx_mag_r  <= 16'(pxt[17] ? -pxt : pxt);
          ny_mag_r  <= 16'(pyt[17] ? -pyt : pyt);
          nx_neg_r  <= (pxt > 18'sd0);
          ny_neg_r  <= (pyt > 18'sd0);
          d_r       <= 17'(ixx + iyy);
          div_idx_r <= '0;
        end

        ST_FDIV: begin
          if (d_r == 17'd0) begin
            // zero gradient gives zero flow
            fx_r <= '0;
            fy_r <= '0;
          end else begin
            if (div_start) div_run_r <= 1'b1;
            if (div_done) begin
              div_run_r <= 1'b0;
              div_idx_r <= div_idx_r + 2'd1;
              if (div_idx_r == 2'd0) begin
                fx_r <= nx_neg_r ? -$signed(div_quo[16:0]) : $signed(div_quo[16:0]);
              end else begin
                fy_r <= ny_neg_r ? -$signed(div_quo[16:0]) : $signed(div_quo[16:0]);
              end
            end
          end
        end

        ST_SQ: sq_r <= 34'(fx_r) * 34'(fx_r);

        ST_SQ2: begin
          v_r        <= sq_r + 34'(fy_r) * 34'(fy_r);
          root_r     <= '0;
          bit_r      <= 34'(1) << 32;
          root_cnt_r <= 5'(ROOT_STEPS - 1);
        end

        ST_ROOT: begin
          // two radicand bits per step
          if (v_r >= root_add) begin
            v_r    <= v_r - root_add;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (root_cnt_r != 5'd0) root_cnt_r <= root_cnt_r - 5'd1;
        end

        ST_PUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= 1'b0;
            out_x_r     <= 11'(c_r - XW'(1));
            out_y_r     <= 11'(r_r - YW'(1));
            out_fx_r    <= fx_r;
            out_fy_r    <= fy_r;
            out_mag_r   <= mag;
            out_gray_r  <= gray;
            out_max_r   <= '0;
            sum_fx_r    <= sum_fx_r + SUMW'(fx_r);
            sum_fy_r    <= sum_fy_r + SUMW'(fy_r);
            sum_m_r     <= sum_m_r + SUMW'(mag);
            if (mag > peak_r) peak_r <= mag;
          end
        end

        ST_CNT: begin
          cnt_r     <= CNTW'(w_last - XW'(1)) * CNTW'(h_last - YW'(1));
          div_idx_r <= '0;
        end

        ST_SDIV: begin
          if (div_start) div_run_r <= 1'b1;
          if (div_done) begin
            div_run_r <= 1'b0;
            div_idx_r <= div_idx_r + 2'd1;
            case (div_idx_r)
              2'd0:    ax_r <= avg_s;
              2'd1:    ay_r <= avg_s;
              default: am_r <= avg_m;
            endcase
          end
        end

        ST_SPUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= 1'b1;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_fx_r    <= ax_r;
            out_fy_r    <= ay_r;
            out_mag_r   <= am_r;
            out_gray_r  <= '0;
            out_max_r   <= peak_r;
            // restart the frame statistics
            sum_fx_r    <= '0;
            sum_fy_r    <= '0;
            sum_m_r     <= '0;
            peak_r      <= '0;
          end
        end

        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_summary     = out_sum_r;
  assign out_pixel_x        = out_x_r;
  assign out_pixel_y        = out_y_r;
  assign out_flow_x         = out_fx_r;
  assign out_flow_y         = out_fy_r;
  assign out_magnitude      = out_mag_r;
  assign out_magnitude_gray = out_gray_r;
  assign out_max_magnitude  = out_max_r;

endmodule
